// ===== rtl/lev_pkg.sv =====
// ----------------------------------------------------------------------------
// lev_pkg
// Shared types, codes and helpers for the LOOK elevator scheduler.
// ----------------------------------------------------------------------------
package lev_pkg;

	// item opcodes
	localparam logic [1:0] OP_LOCATE = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	localparam logic [1:0] OP_MOVE   = 2'd3;

	localparam int FLOOR_W         = 10;    // floor field width
	localparam int FLOOR_LIMIT     = 1024;  // floors the floor field can name
	localparam int FLOOR_COUNT_DEF = 1024;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int WORD_W          = 32;    // occupancy bits per word
	localparam int BIT_W           = 5;     // log2(WORD_W)

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_WORD,
		ST_UPD
	} lev_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // latch item, issue first reads
		logic look;       // evaluate current word and summary
		logic word_step;  // pick floor inside a fetched word
		logic update;     // write back, load result
	} lev_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_move;
		logic sum_hit;    // target lies in another word, fetch needed
	} lev_stat_t;

	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

	function automatic logic [BIT_W-1:0] highest_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (v[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

endpackage

// ===== rtl/lev_ctrl.sv =====
// ----------------------------------------------------------------------------
// lev_ctrl
// Sequencer for the scheduler: accept, look, optional word fetch, update.
// ----------------------------------------------------------------------------
module lev_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lev_pkg::lev_stat_t stat,
	output lev_pkg::lev_cmd_t  cmd,
	output logic              busy,
	output logic              done
);

	lev_pkg::lev_state_t state_q, state_d;
	logic                done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lev_pkg::ST_IDLE: begin
				if (start) state_d = lev_pkg::ST_LOOK;
			end
			lev_pkg::ST_LOOK: begin
				if (stat.is_move && stat.sum_hit) state_d = lev_pkg::ST_WORD;
				else state_d = lev_pkg::ST_UPD;
			end
			lev_pkg::ST_WORD: begin
				state_d = lev_pkg::ST_UPD;
			end
			lev_pkg::ST_UPD: begin
				state_d = lev_pkg::ST_IDLE;
			end
			default: begin
				state_d = lev_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			lev_pkg::ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			lev_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
			end
			lev_pkg::ST_WORD: begin
				cmd.word_step = 1'b1;
			end
			lev_pkg::ST_UPD: begin
				cmd.update = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lev_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == lev_pkg::ST_UPD);
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/lev_datapath.sv =====
// ----------------------------------------------------------------------------
// lev_datapath
// Request counts, two-level occupancy bitmap, car position and direction.
// ----------------------------------------------------------------------------
module lev_datapath #(
	parameter int FLOOR_COUNT = lev_pkg::FLOOR_COUNT_DEF,
	parameter int COUNT_BITS  = lev_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lev_pkg::lev_cmd_t           cmd,
	input  logic [1:0]                  op,
	input  logic [lev_pkg::FLOOR_W-1:0] target_floor,
	output lev_pkg::lev_stat_t          stat,
	output logic [lev_pkg::FLOOR_W-1:0] car_floor,
	output logic                        heading_up,
	output logic                        moved
);

	localparam int FW     = lev_pkg::FLOOR_W;
	localparam int BW     = lev_pkg::BIT_W;
	localparam int WW     = lev_pkg::WORD_W;
	// floors beyond what the floor field can name never hold requests
	localparam int FLOORS = (FLOOR_COUNT < lev_pkg::FLOOR_LIMIT) ?
		FLOOR_COUNT : lev_pkg::FLOOR_LIMIT;
	localparam int FB     = $clog2(FLOORS);
	localparam int NWORDS = (FLOORS + WW - 1) / WW;
	localparam int WB     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam logic [FW:0] FLOORS_L = (FW + 1)'(FLOORS);

	// storage
	logic [COUNT_BITS-1:0] cnt_mem [FLOORS];
	logic [WW-1:0]         occ_mem [NWORDS];
	logic [NWORDS-1:0]     summary_q;   // word holds any request; clear word reads as zero

	logic [1:0]            op_q;
	logic [FW-1:0]         dest_q, pos_q;
	logic                  dir_q;
	logic [WW-1:0]         word_q, occ_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic                  found_q, flip_q, srch_up_q;
	logic [WB-1:0]         sw_q;
	logic [FW-1:0]         car_floor_q;
	logic                  heading_q, moved_q;

	// look stage
	logic              is_move;
	logic [WB-1:0]     pw, look_w;
	logic [BW-1:0]     pb;
	logic [WW-1:0]     cur_word, above_in, below_in;
	logic [NWORDS-1:0] sum_above, sum_below;
	logic              up_in, dn_in, up_hit, dn_hit, go_up, any_hit, here, in_hit;
	logic [BW-1:0]     in_bit, sum_lo, sum_hi;
	logic [WB-1:0]     sum_idx;
	logic [FW-1:0]     in_dest, look_dest;

	// word stage
	logic [BW-1:0]     wbit;
	logic [FW-1:0]     word_dest;

	// memory ports
	logic [FW-1:0]     cnt_ra, acc_floor;
	logic              cnt_re, occ_re;
	logic [WB-1:0]     occ_ra;

	// update stage
	logic [BW-1:0]         u_bit;
	logic [WB-1:0]         u_word;
	logic [COUNT_BITS-1:0] u_cnt, new_cnt;
	logic                  wr, in_range, served;
	logic [WW-1:0]         new_word;

	assign is_move = (op_q == lev_pkg::OP_MOVE);
	assign pw      = pos_q[BW +: WB];
	assign pb      = pos_q[BW-1:0];
	assign look_w  = is_move ? pw : dest_q[BW +: WB];
	assign cur_word = summary_q[look_w] ? occ_rd_q : '0;

	always_comb begin
		for (int i = 0; i < WW; i++) begin
			above_in[i] = cur_word[i] & (BW'(i) > pb);
			below_in[i] = cur_word[i] & (BW'(i) < pb);
		end
		for (int j = 0; j < NWORDS; j++) begin
			sum_above[j] = summary_q[j] & (WB'(j) > pw);
			sum_below[j] = summary_q[j] & (WB'(j) < pw);
		end
	end

	assign up_in   = |above_in;
	assign dn_in   = |below_in;
	assign up_hit  = up_in | (|sum_above);
	assign dn_hit  = dn_in | (|sum_below);
	// keep heading while it has work, else turn around
	assign go_up   = dir_q ? up_hit : !dn_hit;
	assign any_hit = up_hit | dn_hit;
	assign here    = cur_word[pb];
	assign in_hit  = go_up ? up_in : dn_in;
	assign in_bit  = go_up ? lev_pkg::lowest_set(above_in) : lev_pkg::highest_set(below_in);
	assign sum_lo  = lev_pkg::lowest_set(WW'(sum_above));
	assign sum_hi  = lev_pkg::highest_set(WW'(sum_below));
	assign sum_idx = go_up ? sum_lo[WB-1:0] : sum_hi[WB-1:0];
	assign in_dest = FW'({pw, in_bit});
	assign look_dest = here ? pos_q : in_dest;

	assign stat.is_move = is_move;
	assign stat.sum_hit = any_hit & !here & !in_hit;

	assign wbit      = srch_up_q ? lev_pkg::lowest_set(occ_rd_q) : lev_pkg::highest_set(occ_rd_q);
	assign word_dest = FW'({sw_q, wbit});

	// read port control
	assign acc_floor = (op == lev_pkg::OP_MOVE) ? pos_q : target_floor;
	assign cnt_re = cmd.accept | (cmd.look & is_move & !here & in_hit) | cmd.word_step;
	assign cnt_ra = cmd.accept ? acc_floor : (cmd.look ? look_dest : word_dest);
	assign occ_re = cmd.accept | (cmd.look & is_move & stat.sum_hit);
	assign occ_ra = cmd.accept ? acc_floor[BW +: WB] : sum_idx;

	// update
	assign u_bit    = dest_q[BW-1:0];
	assign u_word   = dest_q[BW +: WB];
	assign u_cnt    = word_q[u_bit] ? cnt_rd_q : '0;
	assign in_range = ({1'b0, dest_q} < FLOORS_L);
	assign served   = is_move & found_q;

	always_comb begin
		wr      = 1'b0;
		new_cnt = u_cnt;
		case (op_q)
			lev_pkg::OP_ADD: begin
				wr      = in_range && (dest_q != pos_q) && (u_cnt != '1);
				new_cnt = u_cnt + 1'b1;
			end
			lev_pkg::OP_CANCEL: begin
				wr      = in_range && (u_cnt != '0);
				new_cnt = u_cnt - 1'b1;
			end
			lev_pkg::OP_MOVE: begin
				wr      = found_q;
				new_cnt = u_cnt - 1'b1;
			end
			default: begin
				wr      = 1'b0;
				new_cnt = u_cnt;
			end
		endcase
		for (int i = 0; i < WW; i++) begin
			new_word[i] = (BW'(i) == u_bit) ? (|new_cnt) : word_q[i];
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.update && wr) begin
			cnt_mem[dest_q[FB-1:0]] <= new_cnt;
			occ_mem[u_word]         <= new_word;
		end
		if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra[FB-1:0]];
		if (occ_re) occ_rd_q <= occ_mem[occ_ra];
	end

	// item payload and search state
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			dest_q <= target_floor;
		end
		if (cmd.look) begin
			word_q    <= cur_word;
			found_q   <= here | any_hit;
			flip_q    <= !here & (go_up != dir_q);
			srch_up_q <= go_up;
			sw_q      <= sum_idx;
			if (is_move && (here || in_hit)) dest_q <= look_dest;
		end
		if (cmd.word_step) begin
			word_q <= occ_rd_q;
			dest_q <= word_dest;
		end
	end

	// architectural state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q   <= '0;
			pos_q       <= '0;
			dir_q       <= 1'b1;
			car_floor_q <= '0;
			heading_q   <= 1'b1;
			moved_q     <= 1'b0;
		end else if (cmd.update) begin
			if (wr) summary_q[u_word] <= |new_word;
			if (served) pos_q <= dest_q;
			dir_q       <= dir_q ^ (served & flip_q);
			car_floor_q <= served ? dest_q : pos_q;
			heading_q   <= dir_q ^ (served & flip_q);
			moved_q     <= served;
		end
	end

	assign car_floor  = car_floor_q;
	assign heading_up = heading_q;
	assign moved      = moved_q;

endmodule

// ===== rtl/look_elevator_scheduler.sv =====
// ----------------------------------------------------------------------------
// look_elevator_scheduler
// LOOK elevator scheduler: per-floor request counts, car position, heading.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  item in  | start, busy            | op, target_floor
//  result   | done (one-cycle pulse) | car_floor, heading_up, moved
//
//  An item is taken on an edge with start high and busy low. Every item steps
//  through accept, look and update, and done is registered from the update
//  step; a move adds a word step between look and update when the next
//  request lies in another 32-floor word and that bitmap word has to be
//  fetched from the occupancy RAM. busy drops in the done cycle, so the next
//  item may be taken there. No clearing pass after reset: a per-word summary
//  bit, cleared by reset, marks which bitmap words are live, and a count
//  reads as zero while its occupancy bit is clear. done cannot be held off.
//
// Search: the current word is masked above and below the car, and the
// summary bits above and below the car's word, all in the same cycle. The nearest
// request in the current heading wins; with none that way the car turns.
// A request at the car's own floor is served in place.
// ----------------------------------------------------------------------------
module look_elevator_scheduler #(
	parameter int FLOOR_COUNT = lev_pkg::FLOOR_COUNT_DEF,
	parameter int COUNT_BITS  = lev_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  op,
	input  logic [lev_pkg::FLOOR_W-1:0] target_floor,
	output logic                        busy,
	output logic                        done,
	output logic [lev_pkg::FLOOR_W-1:0] car_floor,
	output logic                        heading_up,
	output logic                        moved
);

	lev_pkg::lev_cmd_t  cmd;
	lev_pkg::lev_stat_t stat;

	// sequencer
	lev_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// counts, bitmap, position, heading
	lev_datapath #(
		.FLOOR_COUNT (FLOOR_COUNT),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.target_floor (target_floor),
		.stat         (stat),
		.car_floor    (car_floor),
		.heading_up   (heading_up),
		.moved        (moved)
	);

endmodule

// ===== rtl/lev_checker.sv =====
// ----------------------------------------------------------------------------
// lev_checker
// Port-level checks on item and result timing for the scheduler.
// ----------------------------------------------------------------------------
module lev_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic [1:0]                  op,
	input logic                        busy,
	input logic                        done,
	input logic                        moved
);

	// result pulses only while idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// taken item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accept");

	// non-move items finish in fixed time and never report a move
	a_fixed_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op != lev_pkg::OP_MOVE)) |-> ##3 (done && !moved))
		else $error("non-move item timing or moved flag wrong");

	// one pulse per item
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held two cycles");

endmodule

bind look_elevator_scheduler lev_checker u_lev_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.op     (op),
	.busy   (busy),
	.done   (done),
	.moved  (moved)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LOOK elevator scheduler. A clocked driver issues
// locate, add, cancel and move items from a queue of pending items. A clocked
// monitor checks every done pulse against a cycle-free model of the request
// counts, car floor and heading. The run has a directed opening, a burst that
// saturates one floor counter and drains it again, and three random phases
// with different sender idle rates.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FW        = lev_pkg::FLOOR_W;
	localparam int FLOORS    = lev_pkg::FLOOR_COUNT_DEF;
	localparam int CNT_W     = 4;     // narrow counters so saturation is reachable
	localparam int STALL_MAX = 2000;  // cycles without any accept or result
	localparam int TAIL      = 12;    // quiet cycles after the last result
	localparam int PHASE_LEN = 600;   // random items per idle profile
	localparam int SAT_FLOOR = 777;

	// one item waiting to be driven, with its sender behavior
	typedef struct packed {
		logic [1:0]    op;
		logic [FW-1:0] floor_no;
		logic [6:0]    idle_pct;  // chance per cycle that the sender holds back
		logic          drain;     // wait for all results before this item
	} request_t;

	// one expected done pulse
	typedef struct packed {
		logic [FW-1:0] car;
		logic          up;
		logic          served;
	} car_report_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [1:0]    op = lev_pkg::OP_LOCATE;
	logic [FW-1:0] target_floor = '0;
	logic          busy;
	logic          done;
	logic [FW-1:0] car_floor;
	logic          heading_up;
	logic          moved;

	// model state: pending calls per floor, car floor, heading
	logic [CNT_W-1:0] calls_at [FLOORS];
	logic [FW-1:0]    model_car = '0;
	logic             model_up = 1'b1;

	request_t    requests_todo[$];
	car_report_t car_reports_due[$];

	int items_taken = 0;   // accepted items (driver, nonblocking)
	int results_seen = 0;  // done pulses (monitor, nonblocking)
	int mismatches = 0;
	int stall_cycles = 0;
	int served_moves = 0;
	int op_seen [4] = '{0, 0, 0, 0};

	look_elevator_scheduler #(
		.FLOOR_COUNT (FLOORS),
		.COUNT_BITS  (CNT_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.target_floor (target_floor),
		.busy         (busy),
		.done         (done),
		.car_floor    (car_floor),
		.heading_up   (heading_up),
		.moved        (moved)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < FLOORS; i++) calls_at[i] = '0;
	end

	// Apply one item to the model, return what the block must report.
	function automatic car_report_t schedule_item(input logic [1:0] code,
			input logic [FW-1:0] fl);
		car_report_t r;
		int f;
		int dest;
		r.served = 1'b0;
		dest = -1;
		case (code)
		lev_pkg::OP_ADD: begin
			// own floor dropped, counter saturates
			if (int'(fl) < FLOORS && fl != model_car && calls_at[fl] != '1)
				calls_at[fl] = calls_at[fl] + 1'b1;
		end
		lev_pkg::OP_CANCEL: begin
			if (int'(fl) < FLOORS && calls_at[fl] != '0)
				calls_at[fl] = calls_at[fl] - 1'b1;
		end
		lev_pkg::OP_MOVE: begin
			if (calls_at[model_car] != '0) begin
				// call at the car's own floor: served in place
				calls_at[model_car] = calls_at[model_car] - 1'b1;
				r.served = 1'b1;
			end else begin
				// pass 0 looks ahead, pass 1 looks behind and turns the car
				for (int pass = 0; pass < 2 && dest < 0; pass++) begin
					if (model_up ^ (pass == 1)) begin
						for (f = int'(model_car) + 1; f < FLOORS && dest < 0; f++)
							if (calls_at[f] != '0) dest = f;
					end else begin
						for (f = int'(model_car) - 1; f >= 0 && dest < 0; f--)
							if (calls_at[f] != '0) dest = f;
					end
					if (dest >= 0 && pass == 1) model_up = ~model_up;
				end
				if (dest >= 0) begin
					model_car = FW'(dest);
					calls_at[dest] = calls_at[dest] - 1'b1;
					r.served = 1'b1;
				end
			end
		end
		default: ;
		endcase
		r.car = model_car;
		r.up  = model_up;
		return r;
	endfunction

	task automatic queue_item(input logic [1:0] code, input int fl, input int idle,
			input bit drain);
		request_t q;
		q.op       = code;
		q.floor_no = FW'(fl);
		q.idle_pct = 7'(idle);
		q.drain    = drain;
		requests_todo.push_back(q);
	endtask

	// Driver: start held until taken; at most one update of start per edge.
	always @(posedge clk) begin : drive
		request_t nxt;
		bit       taken;
		bit       go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				car_reports_due.push_back(schedule_item(op, target_floor));
				op_seen[op]++;
			end
			items_taken <= items_taken + int'(taken);
			go = 1'b0;
			if ((taken || !start) && requests_todo.size() != 0) begin
				nxt = requests_todo[0];
				// drain pause: hold off until every issued item has reported
				go = !(nxt.drain && (items_taken + int'(taken)) != results_seen) &&
					($urandom_range(99) >= nxt.idle_pct);
				if (go) begin
					nxt = requests_todo.pop_front();
					op <= nxt.op;
					target_floor <= nxt.floor_no;
				end
			end
			if (taken || !start) start <= go;
		end
	end

	// Monitor: every done pulse is taken and checked against the oldest report.
	always @(posedge clk) begin : check
		car_report_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (moved) served_moves++;
			if (car_reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: unexpected result floor=%0d up=%0b moved=%0b",
						$realtime, car_floor, heading_up, moved);
			end else begin
				want = car_reports_due.pop_front();
				if (want.car !== car_floor || want.up !== heading_up ||
						want.served !== moved) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%t: mismatch exp floor=%0d up=%0b moved=%0b,",
							" got floor=%0d up=%0b moved=%0b"},
							$realtime, want.car, want.up, want.served,
							car_floor, heading_up, moved);
				end
			end
		end
	end

	// Watchdog on cycles with neither an item nor a result taken.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_MAX) begin
			$display("%t: no progress for %0d cycles", $realtime, STALL_MAX);
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : run
		int                 hot;
		int                 r;
		int                 s;
		int                 fl;
		logic [1:0]         code;

		// directed: idle move, empty cancel, own-floor add, duplicates,
		// in-place service, reversal, bit patterns on the floor field
		queue_item(lev_pkg::OP_LOCATE, 1023, 0, 0);
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);  // nothing pending: car stays
		queue_item(lev_pkg::OP_CANCEL,    5, 0, 0);  // nothing to cancel
		queue_item(lev_pkg::OP_ADD,       0, 0, 0);  // own floor: dropped
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);
		queue_item(lev_pkg::OP_ADD,    1023, 0, 0);
		queue_item(lev_pkg::OP_ADD,    1023, 0, 0);  // duplicate
		queue_item(lev_pkg::OP_ADD,     512, 0, 0);
		queue_item(lev_pkg::OP_ADD,       1, 0, 0);
		queue_item(lev_pkg::OP_CANCEL,  512, 0, 0);
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);  // to 1
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);  // to 1023
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);  // duplicate served in place
		queue_item(lev_pkg::OP_ADD,    1023, 0, 0);  // own floor: dropped
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);  // idle at the top
		queue_item(lev_pkg::OP_ADD,       0, 0, 0);
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);  // turns down to 0
		queue_item(lev_pkg::OP_ADD,    1022, 0, 0);
		queue_item(lev_pkg::OP_ADD,     682, 0, 0);
		queue_item(lev_pkg::OP_ADD,     341, 0, 0);
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);  // heading down, nothing below: turns
		queue_item(lev_pkg::OP_MOVE,    682, 0, 0);
		queue_item(lev_pkg::OP_MOVE,      0, 0, 0);
		queue_item(lev_pkg::OP_LOCATE,    0, 0, 0);

		// saturate one counter, serve it twice, then cancel it past empty
		for (int i = 0; i < (1 << CNT_W) + 1; i++)
			queue_item(lev_pkg::OP_ADD, SAT_FLOOR, 0, i == 0);
		queue_item(lev_pkg::OP_LOCATE, 0, 0, 0);
		queue_item(lev_pkg::OP_MOVE,   0, 0, 0);
		queue_item(lev_pkg::OP_MOVE,   0, 0, 0);
		for (int i = 0; i < (1 << CNT_W); i++)
			queue_item(lev_pkg::OP_CANCEL, SAT_FLOOR, 0, 0);
		queue_item(lev_pkg::OP_MOVE,   0, 0, 0);

		// random: calls clustered around a drifting hot spot, word edges, any floor
		hot = $urandom_range(FLOORS - 1);
		for (int ph = 0; ph < 3; ph++) begin
			for (int n = 0; n < PHASE_LEN; n++) begin
				r = $urandom_range(99);
				code = (r < 38) ? lev_pkg::OP_ADD : (r < 72) ? lev_pkg::OP_MOVE :
					(r < 86) ? lev_pkg::OP_CANCEL : lev_pkg::OP_LOCATE;
				if ($urandom_range(49) == 0) hot = $urandom_range(FLOORS - 1);
				s = $urandom_range(9);
				if (s < 5)
					fl = (hot + $urandom_range(80) - 40) & (FLOORS - 1);
				else if (s < 8)
					fl = $urandom_range(FLOORS - 1);
				else
					fl = ($urandom_range(31) << 5) + ($urandom_range(1) ? 31 : 0);
				queue_item(code, fl, (ph == 0) ? 35 : (ph == 1) ? 76 : 0, n == 0);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (requests_todo.size() != 0 || start || items_taken != results_seen);
		repeat (TAIL) @(negedge clk);

		if (car_reports_due.size() != 0) begin
			mismatches += car_reports_due.size();
			$display("%0d results never arrived", car_reports_due.size());
		end
		$display("ran %0d items: %0d add, %0d cancel, %0d locate, %0d move (%0d served)",
			items_taken, op_seen[lev_pkg::OP_ADD], op_seen[lev_pkg::OP_CANCEL],
			op_seen[lev_pkg::OP_LOCATE], op_seen[lev_pkg::OP_MOVE], served_moves);
		$display("sender idle 35/76/0 pct, drain pauses, one counter saturated; %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
